/* hw/rtl/rrt_pkg.sv */
// Shared types and constants of the rational rate timeline.
package rrt_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned WideW = 2 * WordW;

  localparam logic [63:0] SpeedScale = 64'd1000000;
  localparam logic [39:0] MaxSpeed   = 40'd1000000000000;
  localparam logic [63:0] TickMax    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [29:0] SrcRateRst = 30'd1000000;

  localparam logic [2:0] CmdRead    = 3'd0;
  localparam logic [2:0] CmdPause   = 3'd1;
  localparam logic [2:0] CmdUnpause = 3'd2;
  localparam logic [2:0] CmdSpeed   = 3'd3;
  localparam logic [2:0] CmdRate    = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [62:0] source_time;
    logic [39:0] scaled_speed;
    logic [29:0] tick_rate;
  } in_t;

  typedef struct packed {
    logic [62:0] now_ticks;
    logic        is_paused;
    logic        rejected;
  } out_t;

endpackage

/* hw/rtl/rrt_mul.sv */
// Bit-serial shift-add multiplier, 64 by 64 bits into 128 bits.
module rrt_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [rrt_pkg::WordW-1:0]  a_i,
  input  logic [rrt_pkg::WordW-1:0]  b_i,
  output logic                       done_o,
  output logic [rrt_pkg::WideW-1:0]  p_o
);
  import rrt_pkg::*;

  logic [WideW-1:0] p_q;
  logic [WordW-1:0] a_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [WordW:0]   sum;

  assign sum = {1'b0, p_q[WideW-1:WordW]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      p_q    <= '0;
      a_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
        p_q    <= {{WordW{1'b0}}, b_i};
        a_q    <= a_i;
      end else if (busy_q) begin
        p_q   <= {sum, p_q[WordW-1:1]};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

/* hw/rtl/rrt_div.sv */
// Bit-serial restoring divider, 128 by 64 bits, one quotient bit a cycle.
module rrt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [rrt_pkg::WideW-1:0]  n_i,
  input  logic [rrt_pkg::WordW-1:0]  d_i,
  output logic                       done_o,
  output logic [rrt_pkg::WideW-1:0]  q_o,
  output logic [rrt_pkg::WordW-1:0]  r_o
);
  import rrt_pkg::*;

  logic [WideW-1:0] n_q;
  logic [WordW-1:0] r_q, d_q, r_sh;
  logic [6:0]       cnt_q;
  logic             busy_q, done_q, ge;

  assign r_sh = {r_q[WordW-2:0], n_q[WideW-1]};
  assign ge   = r_q[WordW-1] || (r_sh >= d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
        n_q    <= n_i;
        r_q    <= '0;
        d_q    <= d_i;
      end else if (busy_q) begin
        n_q   <= {n_q[WideW-2:0], ge};
        r_q   <= ge ? r_sh - d_q : r_sh;
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = n_q;
  assign r_o    = r_q;

endmodule

/* hw/rtl/rational_rate_timeline_unit.sv */
// Rational rate timeline: command sequencer around a serial multiplier and divider.
// An unpaused read runs two divides and two multiplies before its beat leaves; a paused read
// runs none. A set command adds one divide per gcd remainder step and several more divides
// and multiplies.
// One command is worked at a time; the next beat is taken once the result is loaded.
// Reset clears all state at once, with no clearing pass.
module rational_rate_timeline_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [29:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rrt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rrt_pkg::out_t out_data_o
);
  import rrt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_GCD_CHK, ST_GCD_W, ST_SPN_W, ST_SPD_W,
    ST_MR_DEN, ST_MR_DEN_W, ST_MR_NUM_W, ST_MR_MOD_W, ST_MR_Q_W, ST_MR_DD_W,
    ST_SC_DIV1, ST_SC_DIV1_W, ST_SC_MUL1_W, ST_SC_DIV2_W, ST_SC_MUL2_W,
    ST_SC_SAT, ST_AFTER, ST_AP_MUL_W, ST_AP_DIV_W, ST_FINAL, ST_OUT
  } state_e;

  typedef enum logic [1:0] {AFT_PAUSE, AFT_UNPAUSE, AFT_RATE} aft_e;

  state_e state_q;
  aft_e   aft_q;

  logic [29:0] src_rate_q, trate_q;
  logic [63:0] banked_q, carry_q, start_q, rnum_q, rden_q;
  logic [39:0] snum_q;
  logic [19:0] sden_q;
  logic        paused_q;

  logic [2:0]  cmd_q;
  logic [62:0] t_q;
  logic [39:0] speed_q;
  logic [29:0] trate_in_q, mr_trate_q;
  logic [39:0] mr_snum_q;
  logic [19:0] mr_sden_q;
  logic        rej_q, gret_q, final_q;
  logic [63:0] ga_q, gb_q, g_q, raw_den_q, new_num_q, new_den_q, q1_q, newrem_q;
  logic [127:0] raw_num_q, q2_q, gain_q;
  logic [62:0] now_q;

  logic        out_valid_q;
  out_t        out_q;

  logic             mul_go_q, mul_done, div_go_q, div_done;
  logic [63:0]      mul_a_q, mul_b_q, div_d_q, div_r;
  logic [127:0]     mul_p, div_n_q, div_q;

  logic [29:0]  src_eff;
  logic [63:0]  t_ext, elapsed, sat_res;

  rrt_mul u_mul (
    .clk_i, .rst_ni, .go_i(mul_go_q), .a_i(mul_a_q), .b_i(mul_b_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  rrt_div u_div (
    .clk_i, .rst_ni, .go_i(div_go_q), .n_i(div_n_q), .d_i(div_d_q),
    .done_o(div_done), .q_o(div_q), .r_o(div_r)
  );

  assign src_eff = (src_rate_q == '0) ? 30'd1 : src_rate_q;
  assign t_ext   = {1'b0, t_q};
  assign elapsed = (paused_q || t_ext < start_q) ? '0 : t_ext - start_q;
  assign sat_res = (gain_q[127:64] != '0 || gain_q[63:0] > TickMax - banked_q) ?
                   TickMax : banked_q + gain_q[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      aft_q       <= AFT_PAUSE;
      src_rate_q  <= SrcRateRst;
      trate_q     <= SrcRateRst;
      banked_q    <= '0;
      carry_q     <= '0;
      start_q     <= '0;
      rnum_q      <= 64'd1;
      rden_q      <= 64'd1;
      snum_q      <= 40'd1;
      sden_q      <= 20'd1;
      paused_q    <= 1'b0;
      cmd_q       <= CmdRead;
      t_q         <= '0;
      speed_q     <= '0;
      trate_in_q  <= '0;
      mr_trate_q  <= '0;
      mr_snum_q   <= '0;
      mr_sden_q   <= '0;
      rej_q       <= 1'b0;
      gret_q      <= 1'b0;
      final_q     <= 1'b0;
      ga_q        <= '0;
      gb_q        <= '0;
      g_q         <= '0;
      raw_den_q   <= '0;
      raw_num_q   <= '0;
      new_num_q   <= '0;
      new_den_q   <= '0;
      q1_q        <= '0;
      q2_q        <= '0;
      newrem_q    <= '0;
      gain_q      <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      div_n_q     <= '0;
      div_d_q     <= '0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (cfg_we_i) begin
        src_rate_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q      <= in_data_i.command;
            t_q        <= in_data_i.source_time;
            speed_q    <= in_data_i.scaled_speed;
            trate_in_q <= in_data_i.tick_rate;
            rej_q      <= 1'b0;
            state_q    <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          state_q <= ST_FINAL;
          final_q <= 1'b0;
          case (cmd_q)
            CmdPause: begin
              if (!paused_q) begin
                aft_q   <= AFT_PAUSE;
                state_q <= ST_SC_DIV1;
              end
            end
            CmdUnpause: begin
              if (paused_q) begin
                aft_q   <= AFT_UNPAUSE;
                state_q <= ST_SC_DIV1;
              end
            end
            CmdSpeed: begin
              if (speed_q == '0 || speed_q > MaxSpeed) begin
                rej_q <= 1'b1;
              end else begin
                ga_q    <= {24'd0, speed_q};
                gb_q    <= SpeedScale;
                gret_q  <= 1'b0;
                state_q <= ST_GCD_CHK;
              end
            end
            CmdRate: begin
              if (trate_in_q == '0) begin
                rej_q <= 1'b1;
              end else begin
                mr_trate_q <= trate_in_q;
                mr_snum_q  <= snum_q;
                mr_sden_q  <= sden_q;
                state_q    <= ST_MR_DEN;
              end
            end
            default: state_q <= ST_FINAL;
          endcase
        end
        ST_GCD_CHK: begin
          if (gb_q == '0) begin
            if (!gret_q) begin
              div_n_q  <= {88'd0, speed_q};
              div_d_q  <= ga_q;
              div_go_q <= 1'b1;
              state_q  <= ST_SPN_W;
            end else begin
              g_q      <= (ga_q == '0) ? 64'd1 : ga_q;
              div_n_q  <= raw_num_q;
              div_d_q  <= (ga_q == '0) ? 64'd1 : ga_q;
              div_go_q <= 1'b1;
              state_q  <= ST_MR_Q_W;
            end
          end else begin
            div_n_q  <= {64'd0, ga_q};
            div_d_q  <= gb_q;
            div_go_q <= 1'b1;
            state_q  <= ST_GCD_W;
          end
        end
        ST_GCD_W: begin
          if (div_done) begin
            ga_q    <= gb_q;
            gb_q    <= div_r;
            state_q <= ST_GCD_CHK;
          end
        end
        ST_SPN_W: begin
          if (div_done) begin
            mr_snum_q <= div_q[39:0];
            div_n_q   <= {64'd0, SpeedScale};
            div_d_q   <= ga_q;
            div_go_q  <= 1'b1;
            state_q   <= ST_SPD_W;
          end
        end
        ST_SPD_W: begin
          if (div_done) begin
            mr_sden_q  <= div_q[19:0];
            mr_trate_q <= trate_q;
            state_q    <= ST_MR_DEN;
          end
        end
        ST_MR_DEN: begin
          mul_a_q  <= {34'd0, src_eff};
          mul_b_q  <= {44'd0, mr_sden_q};
          mul_go_q <= 1'b1;
          state_q  <= ST_MR_DEN_W;
        end
        ST_MR_DEN_W: begin
          if (mul_done) begin
            raw_den_q <= mul_p[63:0];
            mul_a_q   <= {34'd0, mr_trate_q};
            mul_b_q   <= {24'd0, mr_snum_q};
            mul_go_q  <= 1'b1;
            state_q   <= ST_MR_NUM_W;
          end
        end
        ST_MR_NUM_W: begin
          if (mul_done) begin
            raw_num_q <= mul_p;
            div_n_q   <= mul_p;
            div_d_q   <= raw_den_q;
            div_go_q  <= 1'b1;
            state_q   <= ST_MR_MOD_W;
          end
        end
        ST_MR_MOD_W: begin
          if (div_done) begin
            ga_q    <= raw_den_q;
            gb_q    <= div_r;
            gret_q  <= 1'b1;
            state_q <= ST_GCD_CHK;
          end
        end
        ST_MR_Q_W: begin
          if (div_done) begin
            if (div_q[127:64] != '0 || div_q[63:0] == '0) begin
              rej_q   <= 1'b1;
              state_q <= ST_FINAL;
            end else begin
              new_num_q <= div_q[63:0];
              div_n_q   <= {64'd0, raw_den_q};
              div_d_q   <= g_q;
              div_go_q  <= 1'b1;
              state_q   <= ST_MR_DD_W;
            end
          end
        end
        ST_MR_DD_W: begin
          if (div_done) begin
            new_den_q <= div_q[63:0];
            final_q   <= 1'b0;
            aft_q     <= AFT_RATE;
            state_q   <= ST_SC_DIV1;
          end
        end
        ST_SC_DIV1: begin
          div_n_q  <= {64'd0, elapsed};
          div_d_q  <= rden_q;
          div_go_q <= 1'b1;
          state_q  <= ST_SC_DIV1_W;
        end
        ST_SC_DIV1_W: begin
          if (div_done) begin
            q1_q     <= div_q[63:0];
            mul_a_q  <= div_r;
            mul_b_q  <= rnum_q;
            mul_go_q <= 1'b1;
            state_q  <= ST_SC_MUL1_W;
          end
        end
        ST_SC_MUL1_W: begin
          if (mul_done) begin
            div_n_q  <= mul_p + {64'd0, carry_q};
            div_d_q  <= rden_q;
            div_go_q <= 1'b1;
            state_q  <= ST_SC_DIV2_W;
          end
        end
        ST_SC_DIV2_W: begin
          if (div_done) begin
            q2_q     <= div_q;
            newrem_q <= div_r;
            mul_a_q  <= q1_q;
            mul_b_q  <= rnum_q;
            mul_go_q <= 1'b1;
            state_q  <= ST_SC_MUL2_W;
          end
        end
        ST_SC_MUL2_W: begin
          if (mul_done) begin
            gain_q  <= mul_p + q2_q;
            state_q <= ST_SC_SAT;
          end
        end
        ST_SC_SAT: begin
          if (final_q) begin
            now_q   <= sat_res[62:0];
            state_q <= ST_OUT;
          end else begin
            banked_q <= sat_res;
            carry_q  <= newrem_q;
            start_q  <= t_ext;
            state_q  <= ST_AFTER;
          end
        end
        ST_AFTER: begin
          case (aft_q)
            AFT_PAUSE: begin
              paused_q <= 1'b1;
              state_q  <= ST_FINAL;
            end
            AFT_UNPAUSE: begin
              paused_q <= 1'b0;
              state_q  <= ST_FINAL;
            end
            default: begin
              if (cmd_q == CmdSpeed) begin
                snum_q <= mr_snum_q;
                sden_q <= mr_sden_q;
              end else begin
                trate_q <= trate_in_q;
              end
              mul_a_q  <= carry_q;
              mul_b_q  <= new_den_q;
              mul_go_q <= 1'b1;
              state_q  <= ST_AP_MUL_W;
            end
          endcase
        end
        ST_AP_MUL_W: begin
          if (mul_done) begin
            div_n_q  <= mul_p;
            div_d_q  <= rden_q;
            div_go_q <= 1'b1;
            state_q  <= ST_AP_DIV_W;
          end
        end
        ST_AP_DIV_W: begin
          if (div_done) begin
            carry_q <= div_q[63:0];
            rnum_q  <= new_num_q;
            rden_q  <= new_den_q;
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (paused_q) begin
            now_q   <= banked_q[62:0];
            state_q <= ST_OUT;
          end else begin
            final_q <= 1'b1;
            state_q <= ST_SC_DIV1;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q     <= 1'b1;
            out_q.now_ticks <= now_q;
            out_q.is_paused <= paused_q;
            out_q.rejected  <= rej_q;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) rden_q != '0)
    else $error("Rate denominator became zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) carry_q < rden_q)
    else $error("Carry remainder is not below the rate denominator.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) banked_q <= TickMax)
    else $error("Banked ticks exceed the saturation limit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DECODE)
    else $error("Accepted beat did not start decoding.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(paused_q) |-> $past(state_q == ST_AFTER))
    else $error("Pause state changed outside the update step.");

endmodule

/* test/rational_rate_timeline_unit_tb.sv */
// Self-checking testbench of the rational rate timeline unit with a built-in predictor.
`timescale 1ns / 100ps

module rational_rate_timeline_unit_tb;
  import rrt_pkg::*;

  localparam int unsigned StallLimit  = 100000;
  localparam int unsigned ItemsPerSet = 300;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i = 1'b0;
  logic  [29:0] cfg_data_i = '0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;
  out_t  timeline_q[$];
  row_t  dir_tab[$];

  logic [63:0] src_rate_q;
  logic [63:0] banked_q;
  logic [63:0] carry_q;
  logic [63:0] anchor_q;
  logic        paused_q;
  logic [63:0] rate_num_q;
  logic [63:0] rate_den_q;
  logic [63:0] speed_num_q;
  logic [63:0] speed_den_q;
  logic [63:0] tl_rate_q;

  rational_rate_timeline_unit i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] gcd_u64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic bit derive_rate(input logic [63:0] trate, input logic [63:0] snum,
                                     input logic [63:0] sden, output logic [63:0] num,
                                     output logic [63:0] den);
    logic [63:0]  src;
    logic [63:0]  rden;
    logic [63:0]  g;
    logic [127:0] rnum;
    logic [127:0] rden_w;
    logic [127:0] q;
    num = '0;
    den = 64'd1;
    src = (src_rate_q != 0) ? src_rate_q : 64'd1;
    rden = src * ((sden != 0) ? sden : 64'd1);
    rnum = {64'd0, trate};
    rnum = rnum * {64'd0, snum};
    rden_w = {64'd0, rden};
    g = gcd_u64(rden, 64'(rnum % rden_w));
    if (g == 0) g = 64'd1;
    q = rnum / {64'd0, g};
    if (q[127:64] != 0 || q == 0) return 1'b0;
    num = q[63:0];
    den = rden / g;
    return 1'b1;
  endfunction

  function automatic logic [127:0] ticks_gained(input logic [63:0] elapsed,
                                                inout logic [63:0] rem);
    logic [127:0] part;
    logic [127:0] whole;
    logic [127:0] den_w;
    den_w = {64'd0, rate_den_q};
    part = {64'd0, elapsed % rate_den_q};
    part = part * {64'd0, rate_num_q} + {64'd0, rem};
    rem = 64'(part % den_w);
    whole = {64'd0, elapsed / rate_den_q};
    whole = whole * {64'd0, rate_num_q};
    return whole + part / den_w;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] base, logic [127:0] add);
    if (add[127:64] != 0 || add[63:0] > TickMax - base) return TickMax;
    return base + add[63:0];
  endfunction

  function automatic logic [63:0] elapsed_at(logic [63:0] t);
    return (paused_q || t < anchor_q) ? 64'd0 : t - anchor_q;
  endfunction

  function automatic void bank_ticks(logic [63:0] t);
    banked_q = sat_add(banked_q, ticks_gained(elapsed_at(t), carry_q));
    anchor_q = t;
  endfunction

  function automatic void switch_rate(logic [63:0] num, logic [63:0] den);
    logic [127:0] scaled;
    scaled = {64'd0, carry_q};
    scaled = scaled * {64'd0, den} / {64'd0, rate_den_q};
    rate_num_q = num;
    rate_den_q = den;
    carry_q = scaled[63:0];
  endfunction

  function automatic out_t predict_timeline(in_t d);
    logic [63:0] t;
    logic [63:0] speed;
    logic [63:0] g;
    logic [63:0] sn;
    logic [63:0] sd;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] now;
    bit          rej;
    out_t        res;
    t = {1'b0, d.source_time};
    speed = {24'd0, d.scaled_speed};
    rej = 1'b0;
    case (d.command)
      CmdPause: begin
        if (!paused_q) begin
          bank_ticks(t);
          paused_q = 1'b1;
        end
      end
      CmdUnpause: begin
        if (paused_q) begin
          bank_ticks(t);
          paused_q = 1'b0;
        end
      end
      CmdSpeed: begin
        if (speed < 1 || speed > {24'd0, MaxSpeed}) begin
          rej = 1'b1;
        end else begin
          g = gcd_u64(speed, SpeedScale);
          sn = speed / g;
          sd = SpeedScale / g;
          if (!derive_rate(tl_rate_q, sn, sd, num, den)) begin
            rej = 1'b1;
          end else begin
            bank_ticks(t);
            speed_num_q = sn;
            speed_den_q = sd;
            switch_rate(num, den);
          end
        end
      end
      CmdRate: begin
        if (d.tick_rate == 0 ||
            !derive_rate({34'd0, d.tick_rate}, speed_num_q, speed_den_q, num, den)) begin
          rej = 1'b1;
        end else begin
          bank_ticks(t);
          tl_rate_q = {34'd0, d.tick_rate};
          switch_rate(num, den);
        end
      end
      default: ;
    endcase
    if (paused_q) begin
      now = banked_q;
    end else begin
      rem = carry_q;
      now = sat_add(banked_q, ticks_gained(elapsed_at(t), rem));
    end
    res.now_ticks = now[62:0];
    res.is_paused = paused_q;
    res.rejected = rej;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
    if (out_valid_o && out_ready_i) begin
      if (timeline_q.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_data_o.now_ticks), 64'd0);
      end else begin
        want = timeline_q.pop_front();
        if (out_data_o.now_ticks !== want.now_ticks)
          report_mismatch("now_ticks", 64'(out_data_o.now_ticks), 64'(want.now_ticks));
        if (out_data_o.is_paused !== want.is_paused)
          report_mismatch("is_paused", 64'(out_data_o.is_paused), 64'(want.is_paused));
        if (out_data_o.rejected !== want.rejected)
          report_mismatch("rejected", 64'(out_data_o.rejected), 64'(want.rejected));
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_beat(in_t d, bit typed, out_t want);
    out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_timeline(d);
    timeline_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (timeline_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_source_rate(logic [29:0] v);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    src_rate_q = {34'd0, v};
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_row(logic [2:0] cmd, logic [62:0] t, logic [39:0] speed,
                                  logic [29:0] trate, bit typed, logic [62:0] now,
                                  bit paused, bit rej);
    row_t r;
    r.item = '{command: cmd, source_time: t, scaled_speed: speed, tick_rate: trate};
    r.typed = typed;
    r.want = '{now_ticks: now, is_paused: paused, rejected: rej};
    dir_tab.push_back(r);
  endfunction

  function automatic in_t random_item(inout logic [62:0] clock_now);
    in_t d;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) d.command = CmdRead;
    else if (pick < 45) d.command = CmdPause;
    else if (pick < 60) d.command = CmdUnpause;
    else if (pick < 77) d.command = CmdSpeed;
    else if (pick < 95) d.command = CmdRate;
    else d.command = 3'($urandom_range(5, 7));
    pick = $urandom_range(99);
    if (pick < 88) clock_now = clock_now + 63'($urandom_range(2000000));
    else if (pick < 94) clock_now = clock_now - 63'($urandom_range(1000));
    else clock_now = 63'({$urandom, $urandom});
    d.source_time = clock_now;
    pick = $urandom_range(99);
    if (pick < 65) d.scaled_speed = 40'($urandom_range(1, 20000000));
    else if (pick < 78) d.scaled_speed = MaxSpeed - 40'($urandom_range(3));
    else if (pick < 92) d.scaled_speed = 40'({$urandom, $urandom});
    else d.scaled_speed = '0;
    pick = $urandom_range(99);
    if (pick < 55) d.tick_rate = 30'($urandom_range(1, 1000000000));
    else if (pick < 75) d.tick_rate = 30'($urandom_range(1, 1000));
    else if (pick < 92) d.tick_rate = 30'($urandom);
    else d.tick_rate = '0;
    return d;
  endfunction

  initial begin
    logic [29:0] rate_set[6];
    logic [62:0] clock_now;
    out_t none;
    none = '0;
    rate_set = '{30'd1000000, 30'd1, 30'd1000000000, 30'h3FFF_FFFF, 30'd0, 30'd48000};
    src_rate_q = {34'd0, SrcRateRst};
    banked_q = '0;
    carry_q = '0;
    anchor_q = '0;
    paused_q = 1'b0;
    rate_num_q = 64'd1;
    rate_den_q = 64'd1;
    speed_num_q = 64'd1;
    speed_den_q = 64'd1;
    tl_rate_q = {34'd0, SrcRateRst};

    add_row(CmdRead, 63'd0, 40'd1, 30'd1, 1, 63'd0, 0, 0);
    add_row(CmdRead, 63'd100, 40'd1, 30'd1, 1, 63'd100, 0, 0);
    add_row(CmdPause, 63'd200, 40'd1, 30'd1, 1, 63'd200, 1, 0);
    add_row(CmdPause, 63'd300, 40'd1, 30'd1, 1, 63'd200, 1, 0);
    add_row(CmdRead, 63'd400, 40'd1, 30'd1, 1, 63'd200, 1, 0);
    add_row(CmdUnpause, 63'd500, 40'd1, 30'd1, 1, 63'd200, 0, 0);
    add_row(CmdUnpause, 63'd600, 40'd1, 30'd1, 1, 63'd300, 0, 0);
    add_row(CmdSpeed, 63'd700, 40'd0, 30'd1, 1, 63'd400, 0, 1);
    add_row(CmdSpeed, 63'd800, MaxSpeed + 40'd1, 30'd1, 1, 63'd500, 0, 1);
    add_row(CmdSpeed, 63'd900, '1, '1, 1, 63'd600, 0, 1);
    add_row(CmdRate, 63'd900, 40'd1, 30'd0, 1, 63'd600, 0, 1);
    add_row(CmdRead, 63'd50, '1, '1, 1, 63'd200, 0, 0);
    add_row(3'd5, 63'd1000, 40'd1, 30'd1, 1, 63'd700, 0, 0);
    add_row(3'd7, 63'd1000, 40'd1, 30'd1, 1, 63'd700, 0, 0);
    add_row(3'd6, 63'd1000, 40'd1, 30'd1, 1, 63'd700, 0, 0);
    add_row(CmdSpeed, 63'd2000, 40'd1, 30'd1, 0, '0, 0, 0);
    add_row(CmdRead, 63'd5000000, 40'd1, 30'd1, 0, '0, 0, 0);
    add_row(CmdSpeed, 63'd6000000, MaxSpeed, 30'd1, 0, '0, 0, 0);
    add_row(CmdRate, 63'd7000000, 40'd1, 30'd1000000000, 0, '0, 0, 0);
    add_row(CmdRate, 63'd7000001, 40'd1, '1, 0, '0, 0, 0);
    add_row(CmdRate, 63'd8000000, 40'd1, 30'd1, 0, '0, 0, 0);
    add_row(CmdRead, '1, 40'd1, 30'd1, 0, '0, 0, 0);
    add_row(CmdPause, '1, 40'd1, 30'd1, 0, '0, 0, 0);
    add_row(CmdUnpause, 63'd9000000, 40'd1, 30'd1, 0, '0, 0, 0);
    add_row(CmdRead, 63'd9000003, 40'd1, 30'd1, 0, '0, 0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_beat(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    drain();

    clock_now = '0;
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 82 : 0;
      recv_idle_pct = (ph < 2) ? 82 : (ph < 4) ? 24 : 0;
      write_source_rate(rate_set[ph]);
      for (int n = 0; n < ItemsPerSet; n++) send_beat(random_item(clock_now), 0, none);
      drain();
    end

    repeat (500) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rrt_pkg.sv
hw/rtl/rrt_mul.sv
hw/rtl/rrt_div.sv
hw/rtl/rational_rate_timeline_unit.sv
test/rational_rate_timeline_unit_tb.sv
